@@ rtl/pbo_pkg.sv @@
// ----------------------------------------------------------------------------
// pbo_pkg: shared types and constants of the pulse oscillator
// Formats, command codes, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package pbo_pkg;

   localparam int unsigned CmdW   = 1;
   localparam int unsigned VoiceW = 4;
   localparam int unsigned FreqW  = 25;
   localparam int unsigned PwW    = 16;
   localparam int unsigned SampW  = 18;
   localparam int unsigned SrW    = 18;

   localparam logic [SrW-1:0] SrReset = 18'd48000;
   localparam logic [PwW-1:0] WMin    = 16'd1311;
   localparam logic [PwW-1:0] WMax    = 16'd64225;

   localparam logic [CmdW-1:0] CMD_SAMPLE = 1'b0;
   localparam logic [CmdW-1:0] CMD_RESET  = 1'b1;

   localparam logic [0:0] REG_SAMPLE_RATE = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_INC,
      ST_DIV_R,
      ST_DIV_F,
      ST_SUM,
      ST_DONE
   } state_type;

   // Request to the serial divider: quotient = floor(num / den),
   // num and den given already shifted into place.
   typedef struct packed {
      logic start;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

@@ rtl/pbo_if.sv @@
// ----------------------------------------------------------------------------
// pbo_if: valid/ready channel carrying one word
// Generic handshake interface used for the request and response channels.
// ----------------------------------------------------------------------------
interface pbo_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/polyblep_pulse_oscillator_core.sv @@
// ----------------------------------------------------------------------------
// polyblep_pulse_oscillator_core: multi-voice band-limited pulse oscillator
// ----------------------------------------------------------------------------
// One request word names a voice, a frequency and a duty cycle and yields one
// response word holding the polyBLEP-corrected pulse sample. For a sample
// request a single bit-serial divider produces the phase increment and then
// the normalized position near the rising and the falling edge, one quotient
// bit a cycle into a PHASE_BITS+33-bit quotient; the residuals are then
// summed (ST_SUM) and the sum loaded into the output register (ST_DONE).
// A reset command or an out-of-range voice goes straight to ST_DONE and
// returns 0. One word is in flight at a time; the result sits in an output
// register, and the next request is accepted once the sample is loaded
// there; while the output stalls, the load and the next acceptance wait.
// Voice phases clear on reset; sample_rate (reset 48000) sits at address 0.
// ----------------------------------------------------------------------------
module polyblep_pulse_oscillator_core
   import pbo_pkg::*;
#(
   parameter int unsigned VOICES     = 16,
   parameter int unsigned PHASE_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   pbo_if.sink         req,
   pbo_if.source       rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int unsigned PB    = PHASE_BITS;
   localparam int unsigned NumW  = PB + 33;    // covers freq<<PB and t<<16
   localparam int unsigned DenW  = 33;         // rate*256 and dt
   localparam int unsigned VIdxW = (VOICES > 1) ? $clog2(VOICES) : 1;

   // ---- configuration --------------------------------------------------
   logic [SrW-1:0] sr_ff;
   logic           csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite &&
                   (csr_paddr[1:0] == 2'b00);
   assign csr_prdata = (csr_paddr == 2'b00) ? {{(32-SrW){1'b0}}, sr_ff} : '0;
   always_ff @(posedge clock) begin
      if (reset) sr_ff <= SrReset;
      else if (csr_wr) sr_ff <= csr_pwdata[SrW-1:0];
   end

   // ---- request capture ------------------------------------------------
   logic [CmdW-1:0]   cmd;
   logic [VoiceW-1:0] voice;
   logic [FreqW-1:0]  freq;
   logic [PwW-1:0]    pw;
   assign {cmd, voice, freq, pw} = req.data;

   state_type   state;
   div_ctl_type div_ctl;
   div_sts_type div_sts;
   logic        acc, voice_ok, out_free;
   logic [SampW-1:0] out_ff;
   logic             ov_ff;

   assign req.ready = (state == ST_IDLE);
   assign acc       = req.valid && req.ready;
   assign voice_ok  = ({28'd0, voice} < 32'(VOICES));
   assign out_free  = !ov_ff || rsp.ready;

   // Voice phases, each read at one signal-chosen address: small flop array.
   logic [PB-1:0]    ph_ff [VOICES];
   logic [VIdxW-1:0] vi_ff;
   logic [PB-1:0]    ph_cur_ff, wp_ff;
   logic [PB-1:0]    dt_ff;
   logic [PwW-1:0]   pwc;
   logic [PB-1:0]    tf;

   always_comb begin
      pwc = pw;
      if (pw < WMin) pwc = WMin;
      if (pw > WMax) pwc = WMax;
   end

   // ---- divider operands -----------------------------------------------
   logic [NumW-1:0] d_num, d_quo;
   logic [DenW-1:0] d_den, den_rate;
   logic [PB-1:0]   ph_sel;
   logic [PB-1:0]   dt_raw;
   assign ph_sel   = ph_ff[voice[VIdxW-1:0]];
   assign den_rate = {7'd0, sr_ff, 8'd0};
   assign tf       = ph_cur_ff - wp_ff;

   // Near-edge distance: t itself when t < dt, else 2^PB - t.
   function automatic logic [PB:0] edge_dist(input logic [PB-1:0] t,
                                             input logic [PB-1:0] dt);
      logic [PB:0] r;
      if (t < dt) r = {1'b0, t};
      else r = {1'b1, {PB{1'b0}}} - {1'b0, t};
      return r;
   endfunction

   // The rising-edge division starts as the increment lands, so it takes
   // the fresh increment straight from the divider output.
   always_comb begin
      d_num = '0;
      d_den = {{(DenW-PB){1'b0}}, dt_ff};
      unique case (state)
         ST_IDLE: begin
            d_num = {{(NumW-FreqW-PB){1'b0}}, freq, {PB{1'b0}}};
            d_den = den_rate;
         end
         ST_DIV_INC: begin
            d_num = {{(NumW-PB-17){1'b0}}, edge_dist(ph_cur_ff, dt_raw), 16'd0};
            d_den = {{(DenW-PB){1'b0}}, dt_raw};
         end
         default:    d_num = {{(NumW-PB-17){1'b0}}, edge_dist(tf, dt_ff), 16'd0};
      endcase
   end

   pbo_div #(.NUM_W(NumW), .DEN_W(DenW)) u_div (
      .clock, .reset, .ctl(div_ctl), .num(d_num), .den(d_den),
      .sts(div_sts), .quo(d_quo)
   );

   pbo_ctrl u_ctrl (
      .clock, .reset, .go(acc),
      .is_sample(voice_ok && (cmd == CMD_SAMPLE)),
      .div_sts, .out_free, .state, .div_ctl
   );

   // Residual magnitude from a normalized Q0.16 position; a position of
   // zero gives a full 1.0, so the magnitude needs 17 bits.
   function automatic logic [16:0] blep_mag(input logic [NumW-1:0] q);
      logic [16:0] rem;
      logic [33:0] sq;
      rem = 17'h10000 - {1'b0, q[15:0]};
      sq  = rem * rem;
      return sq[32:16];
   endfunction

   // ---- datapath sequencing --------------------------------------------
   logic signed [19:0] acc_ff;
   logic        rise_near, rise_far, fall_near, fall_far;
   logic        rsgn_ff, fsgn_ff, ract_ff, fact_ff;
   logic [16:0] rmag_ff, fmag_ff;

   // Saturate quotient of increment at one half; zero rate saturates too.
   always_comb begin
      if (sr_ff == '0 || d_quo > NumW'({1'b1, {(PB-1){1'b0}}}))
         dt_raw = {1'b1, {(PB-1){1'b0}}};
      else
         dt_raw = d_quo[PB-1:0];
   end

   assign rise_near = ph_cur_ff < dt_ff;
   assign rise_far  = ({1'b1, {PB{1'b0}}} - {1'b0, ph_cur_ff}) < {1'b0, dt_ff};
   assign fall_near = tf < dt_ff;
   assign fall_far  = ({1'b1, {PB{1'b0}}} - {1'b0, tf}) < {1'b0, dt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < VOICES; i++) ph_ff[i] <= '0;
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= (ov_ff && !rsp.ready) || (state == ST_DONE && out_free);
         if (acc && voice_ok && cmd == CMD_RESET) ph_ff[voice[VIdxW-1:0]] <= '0;
         if (state == ST_SUM) ph_ff[vi_ff] <= ph_cur_ff + dt_ff;
      end
      if (acc) begin
         vi_ff     <= voice[VIdxW-1:0];
         ph_cur_ff <= ph_sel;
         wp_ff     <= {pwc, {(PB-16){1'b0}}};
         acc_ff    <= '0;
      end
      if (state == ST_DIV_INC && div_sts.done) dt_ff <= dt_raw;
      if (state == ST_DIV_R && div_sts.done) begin
         ract_ff <= (dt_ff != '0) && (rise_near || rise_far);
         rsgn_ff <= rise_near;
         rmag_ff <= blep_mag(d_quo);
      end
      if (state == ST_DIV_F && div_sts.done) begin
         fact_ff <= (dt_ff != '0) && (fall_near || fall_far);
         fsgn_ff <= fall_near;
         fmag_ff <= blep_mag(d_quo);
      end
      if (state == ST_SUM) begin
         // naive +/-1, plus rising residual, minus falling residual
         acc_ff <= ((ph_cur_ff < wp_ff) ? 20'sd65536 : -20'sd65536)
            + (ract_ff ? (rsgn_ff ? -$signed({3'd0, rmag_ff})
                                  :  $signed({3'd0, rmag_ff})) : 20'sd0)
            - (fact_ff ? (fsgn_ff ? -$signed({3'd0, fmag_ff})
                                  :  $signed({3'd0, fmag_ff})) : 20'sd0);
      end
      if (state == ST_DONE && out_free) begin
         if (acc_ff > 20'sd131071) out_ff <= 18'h1FFFF;
         else if (acc_ff < -20'sd131072) out_ff <= 18'h20000;
         else out_ff <= acc_ff[SampW-1:0];
      end
   end

   assign rsp.valid = ov_ff;
   assign rsp.data  = out_ff;
endmodule

@@ rtl/pbo_div.sv @@
// ----------------------------------------------------------------------------
// pbo_div: bit-serial restoring divider
// One quotient bit per cycle, MSB first, into an NUM_W-bit quotient.
// ----------------------------------------------------------------------------
module pbo_div
   import pbo_pkg::*;
#(
   parameter int unsigned NUM_W = 57,
   parameter int unsigned DEN_W = 33
) (
   input  logic              clock,
   input  logic              reset,
   input  div_ctl_type       ctl,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output div_sts_type       sts,
   output logic [NUM_W-1:0]  quo
);
   localparam int unsigned CntW = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0]   trial, diff;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DEN_W-1:0], num_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      if (ctl.start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = CntW'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DEN_W]) begin
            rem_in = diff;
         end else begin
            rem_in = trial;
         end
         num_in = {num_ff[NUM_W-2:0], ~diff[DEN_W]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quo      = num_ff;
endmodule

@@ rtl/pbo_ctrl.sv @@
// ----------------------------------------------------------------------------
// pbo_ctrl: sequencer for one request word
// Samples: increment, rising- and falling-edge position divisions, residual sum; else ST_DONE.
// ----------------------------------------------------------------------------
module pbo_ctrl
   import pbo_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic        is_sample,
   input  div_sts_type div_sts,
   input  logic        out_free,
   output state_type   state,
   output div_ctl_type div_ctl
);
   state_type st_ff, st_in;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:    if (go) st_in = is_sample ? ST_DIV_INC : ST_DONE;
         ST_DIV_INC: if (div_sts.done) st_in = ST_DIV_R;
         ST_DIV_R:   if (div_sts.done) st_in = ST_DIV_F;
         ST_DIV_F:   if (div_sts.done) st_in = ST_SUM;
         ST_SUM:     st_in = ST_DONE;
         ST_DONE:    if (out_free) st_in = ST_IDLE;
         default:    st_in = ST_IDLE;
      endcase
   end

   // Divider start pulses on entry to each division state.
   always_comb begin
      div_ctl.start = 1'b0;
      unique case (st_ff)
         ST_IDLE:    div_ctl.start = go && is_sample;
         ST_DIV_INC: div_ctl.start = div_sts.done;
         ST_DIV_R:   div_ctl.start = div_sts.done;
         default:    div_ctl.start = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else st_ff <= st_in;
   end

   assign state = st_ff;
endmodule

@@ rtl/pbo_checker.sv @@
// ----------------------------------------------------------------------------
// pbo_checker: port-level checks on the oscillator
// Watches the handshake and config port of the core.
// ----------------------------------------------------------------------------
module pbo_sva (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [17:0] rsp_data,
   input logic       csr_pready
);
   a_ready: assert property (@(posedge clock) disable iff (reset)
      csr_pready) else $error("pready low");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped");
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word accepted while busy");
   a_rst: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response after reset");
endmodule

bind polyblep_pulse_oscillator_core pbo_sva u_chk (
   .clock, .reset,
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
   .csr_pready
);
